// ----- rtl/html_markup_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTML_MARKUP_TOKENIZER_DEFINES_SVH
`define HTML_MARKUP_TOKENIZER_DEFINES_SVH

// Plain property that holds at every edge.
`define HTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define HTOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/htok_pkg.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer package
// Channel payload types, token kinds, queue sizing and the tag name table.
// ----------------------------------------------------------------------------
package htok_pkg;

  localparam int LEN_W      = 32;
  localparam int QDEPTH     = 4;
  localparam int NUM_NAMES  = 22;
  localparam int NAME_TXT   = 10;  // longest known name, in bytes
  localparam int NAME_SLOTS = 16;  // widest name buffer the block supports

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_INLINE = 2'd2;
  localparam logic [1:0] KIND_BLOCK  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      token_start;
    logic [LEN_W-1:0] token_length;
    logic [1:0]       token_kind;
    logic             in_title;
    logic             final_token;
  } tok_t;

  // Up to two tokens written into the queue per byte, a first.
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    tok_t a;
    tok_t b;
  } push_t;

  typedef struct packed {
    logic [8*NAME_TXT-1:0] txt;  // right-justified, first char highest
    logic [3:0]            len;
    logic                  excl_valid;
    logic [2:0]            excl_bit;
    logic                  block;
    logic                  title;
  } name_entry_t;

  typedef struct packed {
    logic       match;
    logic       excl_valid;
    logic [2:0] excl_bit;
    logic       block;
    logic       title;
  } cls_t;

  // Excluded-element bits: code kbd pre var math samp script textarea.
  localparam name_entry_t KNOWN_NAMES [NUM_NAMES] = '{
    '{"p",          4'd1,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"br",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"dd",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"dt",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h1",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h2",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h3",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h4",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h5",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"h6",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"li",         4'd2,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"div",        4'd3,  1'b0, 3'd0, 1'b1, 1'b0},
    '{"kbd",        4'd3,  1'b1, 3'd1, 1'b0, 1'b0},
    '{"pre",        4'd3,  1'b1, 3'd2, 1'b1, 1'b0},
    '{"var",        4'd3,  1'b1, 3'd3, 1'b0, 1'b0},
    '{"code",       4'd4,  1'b1, 3'd0, 1'b0, 1'b0},
    '{"math",       4'd4,  1'b1, 3'd4, 1'b0, 1'b0},
    '{"samp",       4'd4,  1'b1, 3'd5, 1'b0, 1'b0},
    '{"title",      4'd5,  1'b0, 3'd0, 1'b0, 1'b1},
    '{"script",     4'd6,  1'b1, 3'd6, 1'b0, 1'b0},
    '{"textarea",   4'd8,  1'b1, 3'd7, 1'b0, 1'b0},
    '{"blockquote", 4'd10, 1'b0, 3'd0, 1'b1, 1'b0}
  };

  // Match a collected name against the table; entries are independent.
  function automatic cls_t classify(input logic [NAME_SLOTS-1:0][7:0] name,
                                    input logic [4:0] len);
    cls_t r;
    logic hit;
    r = '0;
    for (int i = 0; i < NUM_NAMES; i++) begin
      hit = ({1'b0, KNOWN_NAMES[i].len} == len);
      for (int j = 0; j < NAME_TXT; j++) begin
        if (j < int'(KNOWN_NAMES[i].len)) begin
          if (name[j] != KNOWN_NAMES[i].txt[8*(int'(KNOWN_NAMES[i].len) - 1 - j) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && !r.match) begin
        r.match      = 1'b1;
        r.excl_valid = KNOWN_NAMES[i].excl_valid;
        r.excl_bit   = KNOWN_NAMES[i].excl_bit;
        r.block      = KNOWN_NAMES[i].block;
        r.title      = KNOWN_NAMES[i].title;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/htok_stream_if.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface htok_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/html_markup_tokenizer.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer
// Splits a byte stream of HTML into text, raw text, inline and block tokens.
// ----------------------------------------------------------------------------
// The block takes one document byte per cycle and gives tokens as start
// offset, length and kind. A byte is accepted in every cycle in which the
// four-entry token queue has room for two more tokens, so with a result side
// that keeps up the input runs at one byte per clock with no gaps; tokens
// leave at up to one per clock through the output register. A token reaches
// the result channel from the byte that closes it through the queue write and
// then the output register. The final byte of a document (last_byte set)
// flushes the open token, marks the last token with final_token and restarts
// the parser at offset zero for the next document. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module html_markup_tokenizer #(
  parameter int MAX_NAME_LEN  = 10,
  parameter int POSITION_BITS = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  htok_stream_if.sink   in_i,
  htok_stream_if.source out_o
);

  // Front to queue: tokens produced by one byte, plus queue room.
  htok_pkg::push_t push;
  logic            room;

  // Queue to back end: head token and pop strobe.
  logic            q_valid;
  htok_pkg::tok_t  q_data;
  logic            pop;

  // Parse bytes, capture and classify tag names, emit finished tokens.
  htok_front #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // Hold tokens so the parser keeps going while the result side stalls.
  htok_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .room_o    (room),
    .q_valid_o (q_valid),
    .q_data_o  (q_data)
  );

  // Present one token per transaction on the result channel.
  htok_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ----- rtl/htok_front.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer front end
// Per-byte parse state machine, tag name capture and classification.
// ----------------------------------------------------------------------------
`include "html_markup_tokenizer_defines.svh"

module htok_front #(
  parameter int MAX_NAME_LEN  = 10,
  parameter int POSITION_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  htok_stream_if.sink     in_i,
  input  logic            room_i,
  output htok_pkg::push_t push_o
);

  localparam int NLW = $clog2(MAX_NAME_LEN + 2);
  localparam int IW  = $clog2(MAX_NAME_LEN);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [19:0] {
    M_TEXT      = 20'h00001,
    M_TAG_START = 20'h00002,
    M_NAME      = 20'h00004,
    M_EXCL      = 20'h00008,
    M_COM_S1    = 20'h00010,
    M_COM       = 20'h00020,
    M_COM_E1    = 20'h00040,
    M_COM_E2    = 20'h00080,
    M_CD_S1     = 20'h00100,
    M_CD_S2     = 20'h00200,
    M_CD_S3     = 20'h00400,
    M_CD_S4     = 20'h00800,
    M_CD_S5     = 20'h01000,
    M_CD_S6     = 20'h02000,
    M_CD        = 20'h04000,
    M_CD_E1     = 20'h08000,
    M_CD_E2     = 20'h10000,
    M_ATTR      = 20'h20000,
    M_SQUO      = 20'h40000,
    M_DQUO      = 20'h80000
  } mode_e;

  mode_e                             mode_q, mode_d;
  logic [POSITION_BITS-1:0]          pos_q, start_q, start_d;
  logic [htok_pkg::LEN_W-1:0]        len_q, len_d, len_inc, e0_len;
  logic [1:0]                        kind_q, kind_d, e0_kind;
  logic [NLW-1:0]                    name_len_q, name_len_d;
  logic                              closing_q, closing_d;
  logic [7:0]                        excl_q, excl_d, excl_mask;
  logic                              title_q, title_d;
  logic [7:0]                        name_q [MAX_NAME_LEN];
  logic [htok_pkg::NAME_SLOTS-1:0][7:0] name_pad;
  htok_pkg::cls_t                    cls;
  logic                              name_we, name_step, do_cls, tag_end;
  logic                              e0_v, e1_v, accept;
  logic [7:0]                        c;
  logic                              last;
  logic [63:0]                       start0_w, start1_w;
  htok_pkg::tok_t                    tok0, tok1;
  logic                              doc_fresh;

  assign c         = in_i.data.data_byte;
  assign last      = in_i.data.last_byte;
  assign in_i.ready = room_i;
  assign accept    = in_i.valid & room_i;

  for (genvar k = 0; k < htok_pkg::NAME_SLOTS; k++) begin : g_pad
    if (k < MAX_NAME_LEN) begin : g_used
      assign name_pad[k] = name_q[k];
    end else begin : g_zero
      assign name_pad[k] = 8'h00;
    end
  end

  assign cls       = htok_pkg::classify(name_pad, 5'(name_len_q));
  assign excl_mask = 8'b1 << cls.excl_bit;
  assign len_inc   = (len_q == '1) ? len_q : len_q + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    start_d    = start_q;
    kind_d     = kind_q;
    name_len_d = name_len_q;
    closing_d  = closing_q;
    excl_d     = excl_q;
    title_d    = title_q;
    name_we    = 1'b0;
    name_step  = 1'b0;
    do_cls     = 1'b0;
    tag_end    = 1'b0;
    e0_v       = 1'b0;
    e0_len     = len_q;
    e0_kind    = kind_q;

    unique case (mode_q)
      M_TEXT: begin
        if (c == CH_LT) begin
          mode_d  = M_TAG_START;
          e0_v    = (len_q != '0);
          start_d = pos_q;
          len_d   = htok_pkg::LEN_W'(1);
          kind_d  = htok_pkg::KIND_INLINE;
        end else begin
          len_d = len_inc;
        end
      end
      M_TAG_START: begin
        closing_d = 1'b0;
        if (c == CH_GT) begin
          // Empty tag: emit it, plain text follows.
          mode_d  = M_TEXT;
          e0_v    = 1'b1;
          e0_len  = len_inc;
          start_d = pos_q + 1'b1;
          len_d   = '0;
          kind_d  = htok_pkg::KIND_TEXT;
        end else if (c == CH_SLASH) begin
          mode_d    = M_NAME;
          closing_d = 1'b1;
          len_d     = len_inc;
        end else if (c == CH_BANG) begin
          mode_d = M_EXCL;
          len_d  = len_inc;
        end else begin
          mode_d    = M_NAME;
          name_step = 1'b1;
        end
      end
      M_NAME: name_step = 1'b1;
      M_EXCL: begin
        len_d  = len_inc;
        mode_d = (c == CH_LBRK) ? M_CD_S1 : (c == CH_DASH) ? M_COM_S1 : M_NAME;
      end
      M_COM_S1: begin
        len_d  = len_inc;
        mode_d = (c == CH_DASH) ? M_COM : M_NAME;
      end
      M_COM: begin
        len_d = len_inc;
        if (c == CH_DASH) mode_d = M_COM_E1;
      end
      M_COM_E1: begin
        len_d  = len_inc;
        mode_d = (c == CH_DASH) ? M_COM_E2 : M_COM;
      end
      M_CD_S1: begin
        len_d  = len_inc;
        mode_d = (c == CH_C) ? M_CD_S2 : M_NAME;
      end
      M_CD_S2: begin
        len_d  = len_inc;
        mode_d = (c == CH_D) ? M_CD_S3 : M_NAME;
      end
      M_CD_S3: begin
        len_d  = len_inc;
        mode_d = (c == CH_A) ? M_CD_S4 : M_NAME;
      end
      M_CD_S4: begin
        len_d  = len_inc;
        mode_d = (c == CH_T) ? M_CD_S5 : M_NAME;
      end
      M_CD_S5: begin
        len_d  = len_inc;
        mode_d = (c == CH_A) ? M_CD_S6 : M_NAME;
      end
      M_CD_S6: begin
        len_d  = len_inc;
        mode_d = (c == CH_LBRK) ? M_CD : M_NAME;
      end
      M_CD: begin
        len_d = len_inc;
        if (c == CH_RBRK) mode_d = M_CD_E1;
      end
      M_CD_E1: begin
        len_d  = len_inc;
        mode_d = (c == CH_RBRK) ? M_CD_E2 : M_CD;
      end
      M_COM_E2, M_CD_E2: begin
        len_d = len_inc;
        if (c == CH_GT) begin
          // Comment or CDATA end closes the token.
          mode_d  = M_TEXT;
          e0_v    = 1'b1;
          e0_len  = len_inc;
          start_d = pos_q + 1'b1;
          len_d   = '0;
          kind_d  = (excl_q != '0) ? htok_pkg::KIND_RAW : htok_pkg::KIND_TEXT;
        end else begin
          mode_d = (mode_q == M_COM_E2) ? M_COM : M_CD;
        end
      end
      M_ATTR: begin
        len_d = len_inc;
        if (c == CH_DQ) mode_d = M_DQUO;
        else if (c == CH_SQ) mode_d = M_SQUO;
        else if (c == CH_GT) tag_end = 1'b1;
      end
      M_SQUO: begin
        len_d = len_inc;
        if (c == CH_SQ) mode_d = M_ATTR;
      end
      M_DQUO: begin
        len_d = len_inc;
        if (c == CH_DQ) mode_d = M_ATTR;
      end
      default: mode_d = M_TEXT;
    endcase

    if (name_step) begin
      len_d = len_inc;
      if (c == CH_SP || c == CH_TAB) begin
        mode_d = M_ATTR;
        do_cls = 1'b1;
      end else if (c == CH_GT) begin
        tag_end = 1'b1;
      end else begin
        name_we = (name_len_q < MAX_NAME_LEN);
        if (name_len_q <= MAX_NAME_LEN) name_len_d = name_len_q + 1'b1;
      end
    end

    if (tag_end) do_cls = 1'b1;

    if (do_cls) begin
      if (cls.match) begin
        if (cls.excl_valid) excl_d = closing_d ? (excl_q & ~excl_mask) : (excl_q | excl_mask);
        if (cls.title) title_d = !closing_d;
        if (cls.block) kind_d = htok_pkg::KIND_BLOCK;
      end
      name_len_d = '0;
    end

    if (tag_end) begin
      mode_d  = M_TEXT;
      e0_v    = 1'b1;
      e0_len  = len_d;
      e0_kind = kind_d;
      start_d = pos_q + 1'b1;
      len_d   = '0;
      kind_d  = (excl_d != '0) ? htok_pkg::KIND_RAW : htok_pkg::KIND_TEXT;
    end
  end

  // Flush the open token on the final byte.
  assign e1_v     = last & (len_d != '0);
  assign start0_w = 64'(start_q);
  assign start1_w = 64'(start_d);

  always_comb begin
    tok0.token_start  = start0_w[31:0];
    tok0.token_length = e0_len;
    tok0.token_kind   = e0_kind;
    tok0.in_title     = title_d;
    tok0.final_token  = last & !e1_v;
    tok1.token_start  = start1_w[31:0];
    tok1.token_length = len_d;
    tok1.token_kind   = kind_d;
    tok1.in_title     = title_d;
    tok1.final_token  = last;
  end

  assign push_o.a_valid = accept & (e0_v | e1_v);
  assign push_o.b_valid = accept & e0_v & e1_v;
  assign push_o.a       = e0_v ? tok0 : tok1;
  assign push_o.b       = tok1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_TEXT;
      pos_q      <= '0;
      start_q    <= '0;
      len_q      <= '0;
      kind_q     <= htok_pkg::KIND_TEXT;
      name_len_q <= '0;
      closing_q  <= 1'b0;
      excl_q     <= '0;
      title_q    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        // End of document: start over at offset zero.
        mode_q     <= M_TEXT;
        pos_q      <= '0;
        start_q    <= '0;
        len_q      <= '0;
        kind_q     <= htok_pkg::KIND_TEXT;
        name_len_q <= '0;
        closing_q  <= 1'b0;
        excl_q     <= '0;
        title_q    <= 1'b0;
      end else begin
        mode_q     <= mode_d;
        pos_q      <= pos_q + 1'b1;
        start_q    <= start_d;
        len_q      <= len_d;
        kind_q     <= kind_d;
        name_len_q <= name_len_d;
        closing_q  <= closing_d;
        excl_q     <= excl_d;
        title_q    <= title_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && name_we) name_q[name_len_q[IW-1:0]] <= c;
  end

  assign doc_fresh = (pos_q == '0) && (mode_q == M_TEXT) && (len_q == '0);

  `HTOK_ASSERT_NEXT(a_doc_restart, accept && last, doc_fresh, "document end did not restart parser")

endmodule

// ----- rtl/htok_queue.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer token queue
// Short queue taking up to two tokens and giving at most one per cycle.
// ----------------------------------------------------------------------------
`include "html_markup_tokenizer_defines.svh"

module htok_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  htok_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            q_valid_o,
  output htok_pkg::tok_t  q_data_o
);

  localparam int PW = $clog2(htok_pkg::QDEPTH);

  htok_pkg::tok_t mem_q [htok_pkg::QDEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;
  logic [1:0]     push_n;

  assign push_n    = {1'b0, push_i.a_valid} + {1'b0, push_i.b_valid};
  assign room_o    = (cnt_q <= (PW+1)'(htok_pkg::QDEPTH - 2));
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) mem_q[wr_q] <= push_i.a;
    if (push_i.b_valid) mem_q[wr_q + 1'b1] <= push_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(push_n);
      rd_q  <= rd_q + PW'(pop_i);
      cnt_q <= cnt_q + (PW+1)'(push_n) - (PW+1)'(pop_i);
    end
  end

  `HTOK_ASSERT(a_no_overflow, cnt_q <= htok_pkg::QDEPTH, "token queue overflow")
  `HTOK_ASSERT_IMP(a_no_underflow, pop_i, cnt_q != '0, "pop from empty token queue")

endmodule

// ----- rtl/htok_back.sv -----
// ----------------------------------------------------------------------------
// HTML markup tokenizer back end
// Output register that drains the token queue onto the result channel.
// ----------------------------------------------------------------------------
module htok_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  htok_pkg::tok_t q_data_i,
  output logic           pop_o,
  htok_stream_if.source  out_o
);

  logic           valid_q;
  htok_pkg::tok_t data_q;

  // Refill whenever the register is empty or being taken.
  assign pop_o = q_valid_i & (!valid_q | out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pop_o | (valid_q & !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= q_data_i;
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule
